>>> src/range_check_watchdog_supervisor_core_defines.svh
// Assertion helpers shared by the supervisor RTL.
`ifndef RANGE_CHECK_WATCHDOG_SUPERVISOR_CORE_DEFINES_SVH
`define RANGE_CHECK_WATCHDOG_SUPERVISOR_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define RCWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define RCWD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> src/rcwd_pkg.sv
package rcwd_pkg;

  // Capacity of the variable window table.
  localparam int unsigned MaxVars = 16;
  localparam int unsigned IdxW    = (MaxVars > 1) ? $clog2(MaxVars) : 1;
  localparam int unsigned CntW    = 8;
  localparam int unsigned DataW   = 32;

  localparam logic [DataW-1:0] InitTimeoutReset = 32'd1000;

  // Item kinds on the input channel.
  localparam logic OpTick  = 1'b0;
  localparam logic OpFrame = 1'b1;

  // Command bytes carried in the low byte of a frame.
  localparam logic [7:0] CmdNone        = 8'd0;
  localparam logic [7:0] CmdInit        = 8'd1;
  localparam logic [7:0] CmdSetCount    = 8'd2;
  localparam logic [7:0] CmdSetPeriod   = 8'd3;
  localparam logic [7:0] CmdRefresh     = 8'd4;
  localparam logic [7:0] CmdReconfigure = 8'd5;

  typedef enum logic [2:0] {
    PhUninit       = 3'd0,
    PhAwaitCfg     = 3'd1,
    PhSetCount     = 3'd2,
    PhSetBounds    = 3'd3,
    PhSetPeriod    = 3'd4,
    PhAwaitRefresh = 3'd5,
    PhCheck        = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    RespNack  = 2'd0,
    RespAck   = 2'd1,
    RespReset = 2'd2
  } resp_e;

  // Update requests from the supervisor control to the window table.
  typedef struct packed {
    logic            clear_all;
    logic            wr_min;
    logic            wr_max;
    logic            set_flag;
    logic            clr_flags;
    logic [IdxW-1:0] idx;
  } tbl_ctrl_t;

endpackage

>>> src/rcwd_var_table.sv
module rcwd_var_table
  import rcwd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbl_ctrl_t          ctrl_i,
  input  logic [DataW-1:0]   wdata_i,
  output logic [DataW-1:0]   min_o,
  output logic [DataW-1:0]   max_o,
  output logic [MaxVars-1:0] flags_o
);

  logic [DataW-1:0]   min_mem [MaxVars];
  logic [DataW-1:0]   max_mem [MaxVars];
  logic [MaxVars-1:0] min_vld_q, min_vld_d;
  logic [MaxVars-1:0] max_vld_q, max_vld_d;
  logic [MaxVars-1:0] flags_q, flags_d;
  logic [MaxVars-1:0] sel;

  assign sel = {{(MaxVars-1){1'b0}}, 1'b1} << ctrl_i.idx;

  // Bound storage; an entry that has not been written since the last clear reads as zero.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_min) begin
      min_mem[ctrl_i.idx] <= wdata_i;
    end
    if (ctrl_i.wr_max) begin
      max_mem[ctrl_i.idx] <= wdata_i;
    end
  end

  // Valid bits and checked flags.
  always_comb begin
    min_vld_d = min_vld_q;
    max_vld_d = max_vld_q;
    flags_d   = flags_q;
    if (ctrl_i.clear_all) begin
      min_vld_d = '0;
      max_vld_d = '0;
    end else begin
      if (ctrl_i.wr_min) begin
        min_vld_d = min_vld_q | sel;
      end
      if (ctrl_i.wr_max) begin
        max_vld_d = max_vld_q | sel;
      end
    end
    priority if (ctrl_i.clr_flags) begin
      flags_d = '0;
    end else if (ctrl_i.set_flag) begin
      flags_d = flags_q | sel;
    end else if (ctrl_i.wr_max) begin
      flags_d = flags_q & ~sel;
    end else begin
      flags_d = flags_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_vld_q <= '0;
      max_vld_q <= '0;
      flags_q   <= '0;
    end else begin
      min_vld_q <= min_vld_d;
      max_vld_q <= max_vld_d;
      flags_q   <= flags_d;
    end
  end

  assign min_o   = min_vld_q[ctrl_i.idx] ? min_mem[ctrl_i.idx] : '0;
  assign max_o   = max_vld_q[ctrl_i.idx] ? max_mem[ctrl_i.idx] : '0;
  assign flags_o = flags_q;

endmodule

>>> src/range_check_watchdog_supervisor_core.sv
// Watchdog supervisor for a supervisee on a serial link.
// Input channel (in_valid_i / in_stall_o): each transaction is one time tick
// (opcode_i = 0) or one received frame (opcode_i = 1, word on frame_data_i).
// Output channel (out_valid_o / out_stall_i): each transaction carries
// response_o: 0 nack, 1 ack, 2 supervisee reset. Ticks that do not expire
// the countdown and empty command bytes produce no transaction.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes the initial
// timeout; write it only while no item is in flight.
// An accepted item is held in the input register and is evaluated as it
// moves on into the response register, which offers its response on the
// output until the receiver takes it.
// One item is accepted per cycle while the receiver does not stall, since
// the evaluation between the input and response registers is combinational.
// When the receiver stalls, the response is held and the input register
// keeps at most one item; in_stall_o rises once that register is blocked.
// Reset empties both registers, enters the uninitialized phase, clears the
// table and loads the countdown and timeout with 1000 ticks.
module range_check_watchdog_supervisor_core
  import rcwd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             opcode_i,
  input  logic [DataW-1:0] frame_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       response_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [DataW-1:0] cfg_data_i
);

`include "range_check_watchdog_supervisor_core_defines.svh"

  // Input register.
  logic             iv_q;
  logic             op_q;
  logic [DataW-1:0] data_q;
  // Output register.
  logic             ov_q, ov_d;
  resp_e            resp_q;
  // Supervisor state.
  phase_e           phase_q, phase_d;
  logic [DataW-1:0] init_q;
  logic [DataW-1:0] countdown_q, countdown_d;
  logic [DataW-1:0] period_q, period_d;
  logic [CntW-1:0]  var_count_q, var_count_d;
  logic [CntW-1:0]  var_index_q, var_index_d;
  logic             bound_half_q, bound_half_d;

  logic             accept;
  logic             proc;
  logic             res_vld;
  resp_e            res_code;
  tbl_ctrl_t        tbl_ctrl;
  logic [DataW-1:0] tbl_min, tbl_max;
  logic [MaxVars-1:0] tbl_flags;
  logic [MaxVars-1:0] count_mask;
  logic [MaxVars-1:0] pass_mask;
  logic             idx_ok;
  logic             win_ok;
  logic             all_ok;
  logic [7:0]       cmd;
  logic [CntW-1:0]  index_inc;

  // Handshake control.
  assign proc        = iv_q && (!ov_q || !out_stall_i);
  assign in_stall_o  = iv_q && !proc;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !iv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (accept) begin
      iv_q <= 1'b1;
    end else if (proc) begin
      iv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      data_q <= frame_data_i;
    end
  end

  // Window table.
  rcwd_var_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tbl_ctrl),
    .wdata_i (data_q),
    .min_o   (tbl_min),
    .max_o   (tbl_max),
    .flags_o (tbl_flags)
  );

  // Shared terms for bound writes and value checks.
  assign cmd       = data_q[7:0];
  assign index_inc = var_index_q + CntW'(1);
  assign idx_ok    = (var_index_q < var_count_q) && (var_index_q < CntW'(MaxVars));
  assign win_ok    = (data_q >= tbl_min) && (data_q <= tbl_max);

  always_comb begin
    for (int i = 0; i < MaxVars; i++) begin
      count_mask[i] = CntW'(i) < var_count_q;
    end
  end

  assign pass_mask = (idx_ok && win_ok) ?
                     ({{(MaxVars-1){1'b0}}, 1'b1} << var_index_q[IdxW-1:0]) : '0;
  assign all_ok    = &(tbl_flags | pass_mask | ~count_mask);

  // Phase machine and per-item evaluation.
  always_comb begin
    phase_d      = phase_q;
    countdown_d  = countdown_q;
    period_d     = period_q;
    var_count_d  = var_count_q;
    var_index_d  = var_index_q;
    bound_half_d = bound_half_q;
    res_vld      = 1'b0;
    res_code     = RespNack;
    tbl_ctrl     = '0;
    tbl_ctrl.idx = var_index_q[IdxW-1:0];

    if (proc) begin
      if (op_q == OpTick) begin
        if (countdown_q > DataW'(1)) begin
          countdown_d = countdown_q - DataW'(1);
        end else begin
          phase_d      = PhUninit;
          bound_half_d = 1'b0;
          countdown_d  = init_q;
          res_vld      = 1'b1;
          res_code     = RespReset;
        end
      end else begin
        unique case (phase_q)
          PhUninit, PhAwaitCfg, PhAwaitRefresh: begin
            res_vld  = (cmd != CmdNone);
            res_code = RespNack;
            if (phase_q == PhUninit) begin
              if (cmd == CmdInit) begin
                countdown_d = init_q;
                phase_d     = PhAwaitCfg;
                res_code    = RespAck;
              end
            end else if (phase_q == PhAwaitCfg) begin
              if (cmd == CmdSetCount) begin
                countdown_d = init_q;
                var_count_d = '0;
                var_index_d = '0;
                phase_d     = PhSetCount;
                res_code    = RespAck;
              end else if (cmd == CmdSetPeriod) begin
                countdown_d = init_q;
                phase_d     = PhSetPeriod;
                res_code    = RespAck;
              end
            end else begin
              if (cmd == CmdRefresh) begin
                if (var_count_q != '0) begin
                  phase_d     = PhCheck;
                  var_index_d = '0;
                end else begin
                  countdown_d = period_q;
                end
                res_code = RespAck;
              end else if (cmd == CmdReconfigure) begin
                countdown_d = init_q;
                phase_d     = PhAwaitCfg;
                res_code    = RespAck;
              end
            end
          end
          PhSetCount: begin
            res_vld = 1'b1;
            if (data_q == '0 || data_q > DataW'(MaxVars)) begin
              var_count_d = '0;
              phase_d     = PhAwaitCfg;
              res_code    = RespNack;
            end else begin
              tbl_ctrl.clear_all = 1'b1;
              tbl_ctrl.clr_flags = 1'b1;
              var_count_d  = data_q[CntW-1:0];
              var_index_d  = '0;
              bound_half_d = 1'b0;
              countdown_d  = init_q;
              phase_d      = PhSetBounds;
              res_code     = RespAck;
            end
          end
          PhSetBounds: begin
            res_vld = 1'b1;
            if (!idx_ok) begin
              bound_half_d = 1'b0;
              phase_d      = PhAwaitCfg;
              res_code     = RespNack;
            end else if (!bound_half_q) begin
              tbl_ctrl.wr_min = 1'b1;
              bound_half_d    = 1'b1;
              res_code        = RespAck;
            end else begin
              tbl_ctrl.wr_max = 1'b1;
              bound_half_d    = 1'b0;
              countdown_d     = init_q;
              var_index_d     = index_inc;
              if (index_inc >= var_count_q) begin
                phase_d = PhAwaitCfg;
              end
              res_code = RespAck;
            end
          end
          PhSetPeriod: begin
            res_vld = 1'b1;
            if (data_q == '0) begin
              res_code = RespNack;
            end else begin
              period_d    = data_q;
              countdown_d = data_q;
              phase_d     = PhAwaitRefresh;
              res_code    = RespAck;
            end
          end
          PhCheck: begin
            res_vld     = 1'b1;
            var_index_d = index_inc;
            if (idx_ok && win_ok) begin
              tbl_ctrl.set_flag = 1'b1;
              res_code          = RespAck;
            end else begin
              phase_d  = PhAwaitRefresh;
              res_code = RespNack;
            end
            // Every configured variable has passed since the last reload.
            if (all_ok) begin
              countdown_d        = period_q;
              tbl_ctrl.clr_flags = 1'b1;
              phase_d            = PhAwaitRefresh;
            end
          end
          default: begin
            phase_d = PhUninit;
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhUninit;
      countdown_q  <= InitTimeoutReset;
      period_q     <= '0;
      var_count_q  <= '0;
      var_index_q  <= '0;
      bound_half_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      countdown_q  <= countdown_d;
      period_q     <= period_d;
      var_count_q  <= var_count_d;
      var_index_q  <= var_index_d;
      bound_half_q <= bound_half_d;
    end
  end

  // Initial timeout register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= InitTimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      init_q <= cfg_data_i;
    end
  end

  // Response register.
  always_comb begin
    ov_d = ov_q;
    if (proc) begin
      ov_d = res_vld;
    end else if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_vld) begin
      resp_q <= res_code;
    end
  end

  assign out_valid_o = ov_q;
  assign response_o  = resp_q;

  // Assertions.
  `RCWD_ASSERT(a_reset_from_tick,
               (proc && res_vld && res_code == RespReset) |-> (op_q == OpTick),
               "supervisee reset without a tick")
  `RCWD_ASSERT(a_count_in_range, var_count_q <= CntW'(MaxVars),
               "variable count above capacity")
  `RCWD_ASSERT(a_stall_cause, in_stall_o |-> (ov_q && out_stall_i),
               "input stalled without a blocked response")
  `RCWD_ASSERT(a_tick_decrement,
               (proc && op_q == OpTick && countdown_q > DataW'(1)) |=>
               (countdown_q == $past(countdown_q) - DataW'(1)),
               "tick did not decrement the countdown")

endmodule

>>> tb/range_check_watchdog_supervisor_core_test.sv
module range_check_watchdog_supervisor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcwd_pkg::*;

  // One tick or frame as it travels on the input channel.
  typedef struct packed {
    logic             op;
    logic [DataW-1:0] data;
  } link_item_t;

  logic             clk_i;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic             opcode_i     = OpTick;
  logic [DataW-1:0] frame_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic [1:0]       response_o;
  logic             cfg_valid_i  = 1'b0;
  logic             cfg_ready_o;
  logic [DataW-1:0] cfg_data_i   = '0;

  // Supervisor state as the testbench predicts it.
  logic [DataW-1:0]   init_timeout = InitTimeoutReset;
  phase_e             sup_phase    = PhUninit;
  logic [DataW-1:0]   countdown    = InitTimeoutReset;
  logic [DataW-1:0]   period       = '0;
  logic [CntW-1:0]    var_count    = '0;
  logic [CntW-1:0]    var_index    = '0;
  logic               max_pending  = 1'b0;
  logic [DataW-1:0]   win_min [MaxVars] = '{default: '0};
  logic [DataW-1:0]   win_max [MaxVars] = '{default: '0};
  logic [MaxVars-1:0] passed       = '0;

  link_item_t link_items[$];
  resp_e      responses_due[$];
  int         queued_items  = 0;
  int         mismatches    = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         item_taken    = 1'b0;

  range_check_watchdog_supervisor_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .frame_data_i(frame_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .response_o  (response_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Advances the predicted state by one accepted item and tells whether it
  // answers, and with what.
  function automatic void supervisor_response(input logic op, input logic [DataW-1:0] data,
                                              output bit answered, output resp_e resp);
    logic [7:0]      cmd;
    logic [CntW-1:0] idx;
    bit              all_passed;
    cmd = data[7:0];
    answered = 1'b1;
    resp = RespNack;
    // A tick counts down; running out resets the supervisee.
    if (op == OpTick) begin
      if (countdown > 1) begin
        countdown = countdown - 1;
        answered = 1'b0;
      end else begin
        sup_phase = PhUninit;
        max_pending = 1'b0;
        countdown = init_timeout;
        resp = RespReset;
      end
      return;
    end
    case (sup_phase)
      PhUninit, PhAwaitCfg, PhAwaitRefresh: begin
        if (sup_phase == PhUninit && cmd == CmdInit) begin
          countdown = init_timeout;
          sup_phase = PhAwaitCfg;
          resp = RespAck;
        end else if (sup_phase == PhAwaitCfg && cmd == CmdSetCount) begin
          countdown = init_timeout;
          var_count = '0;
          var_index = '0;
          sup_phase = PhSetCount;
          resp = RespAck;
        end else if (sup_phase == PhAwaitCfg && cmd == CmdSetPeriod) begin
          countdown = init_timeout;
          sup_phase = PhSetPeriod;
          resp = RespAck;
        end else if (sup_phase == PhAwaitRefresh && cmd == CmdRefresh) begin
          // With no variables a refresh reloads the countdown at once.
          if (var_count != 0) begin
            sup_phase = PhCheck;
            var_index = '0;
          end else begin
            countdown = period;
          end
          resp = RespAck;
        end else if (sup_phase == PhAwaitRefresh && cmd == CmdReconfigure) begin
          countdown = init_timeout;
          sup_phase = PhAwaitCfg;
          resp = RespAck;
        end else if (cmd == CmdNone) begin
          answered = 1'b0;
        end
      end
      PhSetCount: begin
        if (data == 0 || data > MaxVars) begin
          var_count = '0;
          sup_phase = PhAwaitCfg;
        end else begin
          win_min = '{default: '0};
          win_max = '{default: '0};
          passed = '0;
          var_count = data[CntW-1:0];
          var_index = '0;
          max_pending = 1'b0;
          countdown = init_timeout;
          sup_phase = PhSetBounds;
          resp = RespAck;
        end
      end
      PhSetBounds: begin
        if (var_index >= var_count || var_index >= MaxVars) begin
          max_pending = 1'b0;
          sup_phase = PhAwaitCfg;
        end else if (!max_pending) begin
          win_min[var_index[IdxW-1:0]] = data;
          max_pending = 1'b1;
          resp = RespAck;
        end else begin
          win_max[var_index[IdxW-1:0]] = data;
          passed[var_index[IdxW-1:0]] = 1'b0;
          max_pending = 1'b0;
          countdown = init_timeout;
          var_index = var_index + CntW'(1);
          if (var_index >= var_count) begin
            sup_phase = PhAwaitCfg;
          end
          resp = RespAck;
        end
      end
      PhSetPeriod: begin
        if (data != 0) begin
          period = data;
          countdown = data;
          sup_phase = PhAwaitRefresh;
          resp = RespAck;
        end
      end
      PhCheck: begin
        idx = var_index;
        var_index = var_index + CntW'(1);
        if (idx < var_count && idx < MaxVars && data >= win_min[idx[IdxW-1:0]] &&
            data <= win_max[idx[IdxW-1:0]]) begin
          passed[idx[IdxW-1:0]] = 1'b1;
          resp = RespAck;
        end else begin
          sup_phase = PhAwaitRefresh;
        end
        // Once every variable has passed, the countdown restarts with the period.
        all_passed = 1'b1;
        for (int i = 0; i < MaxVars; i++) begin
          if (i < var_count && !passed[i]) begin
            all_passed = 1'b0;
          end
        end
        if (all_passed) begin
          countdown = period;
          passed = '0;
          sup_phase = PhAwaitRefresh;
        end
      end
      default: begin
        sup_phase = PhUninit;
        answered = 1'b0;
      end
    endcase
  endfunction

  function automatic void push_word(input logic [DataW-1:0] w);
    link_items.push_back('{op: OpFrame, data: w});
    queued_items++;
  endfunction

  function automatic void push_tick();
    link_items.push_back('{op: OpTick, data: $urandom()});
    queued_items++;
  endfunction

  // Command frames carry random upper bits half of the time.
  function automatic void push_cmd(input logic [7:0] cmd);
    logic [DataW-1:0] w;
    w = $urandom();
    if ($urandom_range(1)) begin
      w[DataW-1:8] = '0;
    end
    w[7:0] = cmd;
    push_word(w);
  endfunction

  function automatic void maybe_tick(input int pct);
    if ($urandom_range(99) < pct) begin
      push_tick();
    end
  endfunction

  // Queues well-formed supervision sessions with random content, mixed with
  // stray frames and ticks, until the requested number of items is reached.
  task automatic queue_sessions(input int target, input int tick_pct);
    logic [DataW-1:0] lo [MaxVars];
    logic [DataW-1:0] hi [MaxVars];
    logic [DataW-1:0] w;
    logic [DataW-1:0] span;
    int               goal;
    int               n;
    int               pick;
    goal = queued_items + target;
    while (queued_items < goal) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          w = $urandom();
          if ($urandom_range(1)) begin
            w[7:0] = 8'($urandom_range(0, 7));
          end
          if ($urandom_range(2) == 0) begin
            push_tick();
          end else begin
            push_word(w);
          end
        end
      end else begin
        // Reconfigure and init bring the supervisor to configuration from any
        // resting phase.
        push_cmd(CmdReconfigure);
        push_cmd(CmdInit);
        maybe_tick(tick_pct);
        push_cmd(CmdSetCount);
        pick = $urandom_range(19);
        n = 0;
        if (pick == 0) begin
          push_word('0);
        end else if (pick == 1) begin
          w = $urandom();
          if (w <= MaxVars) begin
            w = w + MaxVars + 1;
          end
          push_word(w);
        end else if (pick == 2) begin
          push_word(MaxVars + 1);
        end else begin
          n = (pick == 3) ? 1 : (pick == 4) ? MaxVars : $urandom_range(1, 5);
          push_word(n);
          for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
              0: begin
                lo[i] = '0;
                hi[i] = '1;
              end
              1: begin
                lo[i] = $urandom();
                hi[i] = lo[i] + $urandom_range(0, 8);
                if (hi[i] < lo[i]) begin
                  hi[i] = '1;
                end
              end
              2: begin
                lo[i] = $urandom();
                hi[i] = $urandom();
              end
              default: begin
                lo[i] = $urandom_range(0, 50);
                hi[i] = lo[i] + $urandom_range(0, 50);
              end
            endcase
            push_word(lo[i]);
            maybe_tick(tick_pct / 4);
            push_word(hi[i]);
          end
        end
        // Period, with an occasional rejected zero first.
        push_cmd(CmdSetPeriod);
        if ($urandom_range(5) == 0) begin
          push_word('0);
        end
        case ($urandom_range(9))
          0: w = '1;
          1: w = $urandom();
          default: w = $urandom_range(1, 12);
        endcase
        if (w == 0) begin
          w = 1;
        end
        push_word(w);
        // Refresh rounds, values mostly inside their windows.
        repeat ($urandom_range(1, 4)) begin
          maybe_tick(tick_pct);
          push_cmd(CmdRefresh);
          for (int i = 0; i < n; i++) begin
            span = hi[i] - lo[i];
            case ($urandom_range(9))
              0: w = lo[i];
              1: w = hi[i];
              2: w = lo[i] - 1;
              3: w = hi[i] + 1;
              4: w = $urandom();
              default: begin
                if (hi[i] < lo[i] || span == '1) begin
                  w = $urandom();
                end else begin
                  w = lo[i] + ($urandom() % (span + 1));
                end
              end
            endcase
            push_word(w);
            maybe_tick(tick_pct / 2);
          end
        end
      end
    end
  endtask

  // Holds the sender back until every queued item has gone through and every
  // expected response has arrived.
  task automatic drain();
    do @(posedge clk_i);
    while (link_items.size() != 0 || in_valid_i || responses_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_segment(input logic [DataW-1:0] timeout_ticks, input int send_pct,
                             recv_pct, items, tick_pct);
    // Program the initial timeout while nothing is in flight.
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= timeout_ticks;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    init_timeout = timeout_ticks;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (3) begin
      queue_sessions(items / 3, tick_pct);
      drain();
    end
  endtask

  // Input driver: a new transaction is offered only once the previous one
  // was taken; a stalled transaction holds still.
  always @(negedge clk_i) begin : driver
    link_item_t nxt;
    if (rst_ni) begin
      if (!in_valid_i || item_taken) begin
        if (link_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = link_items.pop_front();
          in_valid_i <= 1'b1;
          opcode_i <= nxt.op;
          frame_data_i <= nxt.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: checks each response transaction, then predicts from each
  // accepted input transaction.
  always @(posedge clk_i) begin : monitor
    bit    answered;
    resp_e resp;
    resp_e want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (responses_due.size() == 0) begin
        $error("response %0d arrived with no transaction expected", response_o);
        mismatches++;
      end else begin
        want = responses_due.pop_front();
        if (response_o !== want) begin
          $error("response mismatch: expected %0d, actual %0d", want, response_o);
          mismatches++;
        end
      end
    end
    item_taken = rst_ni && in_valid_i && !in_stall_o;
    if (item_taken) begin
      supervisor_response(opcode_i, frame_data_i, answered, resp);
      if (answered) begin
        responses_due.push_back(resp);
      end
    end
  end

  initial begin : stimulus
    send_idle_pct = 18;
    recv_idle_pct = 78;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset timeout.
    push_tick();
    push_word(32'hFFFF_FF00);
    push_word(32'h0000_00FF);
    push_word({24'hA5A5A5, CmdInit});
    push_word({24'h0, CmdRefresh});
    push_word({24'h0, CmdSetCount});
    push_word('0);
    push_word({24'h0, CmdSetCount});
    push_word(MaxVars + 1);
    push_word({24'h0, CmdSetCount});
    push_word(1);
    push_word(5);
    push_word('1);
    push_word({24'h0, CmdSetPeriod});
    push_word('0);
    push_word(2);
    push_word({24'h0, CmdRefresh});
    push_word(4);
    push_word({24'h0, CmdRefresh});
    push_word('1);
    push_tick();
    push_tick();
    push_word({24'h0, CmdReconfigure});
    drain();

    // Random part across timeout settings and idling profiles.
    run_segment(32'd12, 18, 78, 280, 20);
    run_segment(32'd1, 18, 78, 210, 10);
    run_segment(32'hFFFF_FFFF, 78, 18, 270, 20);
    run_segment(32'd25, 78, 18, 270, 15);
    run_segment(InitTimeoutReset, 0, 0, 270, 25);
    run_segment($urandom_range(2, 200), 0, 0, 270, 15);

    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop in case the handshakes hang.
  initial begin : run_limit
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/rcwd_pkg.sv
src/rcwd_var_table.sv
src/range_check_watchdog_supervisor_core.sv
tb/range_check_watchdog_supervisor_core_test.sv
